/* sv/ckfu_pkg.sv */
// ----------------------------------------------------------------------------
// ckfu_pkg: shared types and constants of the color keyed upscaler
// Action codes, register indexes, the transparent key and the register set.
// ----------------------------------------------------------------------------
`default_nettype none

package ckfu_pkg;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_SCAN  = 2'd2,
    ACT_IDLE  = 2'd3
  } action_e;

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SCALE_X      = 2'd2;
  localparam logic [1:0] REG_SCALE_Y      = 2'd3;

  localparam logic [7:0] RST_FRAME_WIDTH  = 8'd128;
  localparam logic [7:0] RST_FRAME_HEIGHT = 8'd128;
  localparam logic [3:0] RST_SCALE_X      = 4'd1;
  localparam logic [3:0] RST_SCALE_Y      = 4'd1;

  // A component of all ones in nine bits is -1, the transparent key.
  localparam logic [8:0] COLOR_KEY = 9'h1FF;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // Register values after range limiting.
  typedef struct packed {
    logic [7:0] width;
    logic [7:0] height;
    logic [3:0] scale_x;
    logic [3:0] scale_y;
  } frame_lim_t;

endpackage

`default_nettype wire

/* sv/ckfu_cfg_regs.sv */
// ----------------------------------------------------------------------------
// ckfu_cfg_regs: configuration registers
// Holds frame size and scale factors and limits them to their legal ranges.
// ----------------------------------------------------------------------------
`default_nettype none

module ckfu_cfg_regs
  import ckfu_pkg::*;
#(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int MAX_SCALE  = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       wr_en_i,
  input  wire logic [1:0] wr_index_i,
  input  wire logic [7:0] wr_data_i,
  output frame_lim_t      lim_o
);

  logic [7:0] width_q, height_q;
  logic [3:0] scale_x_q, scale_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= RST_FRAME_WIDTH;
      height_q  <= RST_FRAME_HEIGHT;
      scale_x_q <= RST_SCALE_X;
      scale_y_q <= RST_SCALE_Y;
    end else if (wr_en_i) begin
      case (wr_index_i)
        REG_FRAME_WIDTH:  width_q   <= wr_data_i;
        REG_FRAME_HEIGHT: height_q  <= wr_data_i;
        REG_SCALE_X:      scale_x_q <= wr_data_i[3:0];
        REG_SCALE_Y:      scale_y_q <= wr_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Zero counts as one; values above the maximum are pulled down to it.
  always_comb begin
    if (width_q == 8'd0)               lim_o.width = 8'd1;
    else if (int'(width_q) > MAX_WIDTH) lim_o.width = 8'(MAX_WIDTH);
    else                               lim_o.width = width_q;

    if (height_q == 8'd0)                lim_o.height = 8'd1;
    else if (int'(height_q) > MAX_HEIGHT) lim_o.height = 8'(MAX_HEIGHT);
    else                                 lim_o.height = height_q;

    if (scale_x_q == 4'd0)               lim_o.scale_x = 4'd1;
    else if (int'(scale_x_q) > MAX_SCALE) lim_o.scale_x = 4'(MAX_SCALE);
    else                                 lim_o.scale_x = scale_x_q;

    if (scale_y_q == 4'd0)               lim_o.scale_y = 4'd1;
    else if (int'(scale_y_q) > MAX_SCALE) lim_o.scale_y = 4'(MAX_SCALE);
    else                                 lim_o.scale_y = scale_y_q;
  end

endmodule

`default_nettype wire

/* sv/ckfu_pixel_store.sv */
// ----------------------------------------------------------------------------
// ckfu_pixel_store: frame memory
// One write port and one registered read port, cleared to black after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ckfu_pixel_store
  import ckfu_pkg::*;
#(
  parameter int DEPTH  = 16384,
  parameter int ADDR_W = 14
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  pixel_t                 wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output pixel_t                 rd_data_o,
  output logic                   clear_busy_o
);

  pixel_t mem [DEPTH];

  logic              clr_busy_q;
  logic [ADDR_W-1:0] clr_addr_q;

  logic              we;
  logic [ADDR_W-1:0] wa;
  pixel_t            wd;

  // The clearing pass walks the memory one entry per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == ADDR_W'(DEPTH - 1)) clr_busy_q <= 1'b0;
    end
  end

  assign we = clr_busy_q | wr_en_i;
  assign wa = clr_busy_q ? clr_addr_q : wr_addr_i;
  assign wd = clr_busy_q ? pixel_t'('0) : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) rd_data_o <= mem[rd_addr_i];
  end

  assign clear_busy_o = clr_busy_q;

endmodule

`default_nettype wire

/* sv/ckfu_scan_ctrl.sv */
// ----------------------------------------------------------------------------
// ckfu_scan_ctrl: scan position counters
// Tracks line, line repeat, column and pixel repeat of the upscaled scan.
// ----------------------------------------------------------------------------
`default_nettype none

module ckfu_scan_ctrl
  import ckfu_pkg::*;
#(
  parameter int LINE_W = 7,
  parameter int COL_W  = 7,
  parameter int REP_W  = 3
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  frame_lim_t             lim_i,
  input  wire logic              step_i,
  output logic [LINE_W-1:0]      line_o,
  output logic [COL_W-1:0]       col_o,
  output logic                   last_o
);

  logic [LINE_W-1:0] line_q, line_d, cur_line;
  logic [REP_W-1:0]  lrep_q, lrep_d, cur_lrep;
  logic [COL_W-1:0]  col_q, col_d, cur_col;
  logic [REP_W-1:0]  prep_q, prep_d, cur_prep;
  logic              restart;
  logic [4:0]        prep_inc, lrep_inc;
  logic [8:0]        col_inc, line_inc;
  logic              prep_wrap, col_wrap, lrep_wrap, line_wrap;

  // After a register change the position may lie outside the frame.
  assign restart = (8'(line_q) >= lim_i.height) || (4'(lrep_q) >= lim_i.scale_y) ||
                   (8'(col_q) >= lim_i.width) || (4'(prep_q) >= lim_i.scale_x);

  assign cur_line = restart ? '0 : line_q;
  assign cur_lrep = restart ? '0 : lrep_q;
  assign cur_col  = restart ? '0 : col_q;
  assign cur_prep = restart ? '0 : prep_q;

  assign prep_inc = 5'(cur_prep) + 5'd1;
  assign lrep_inc = 5'(cur_lrep) + 5'd1;
  assign col_inc  = 9'(cur_col) + 9'd1;
  assign line_inc = 9'(cur_line) + 9'd1;

  assign prep_wrap = prep_inc >= {1'b0, lim_i.scale_x};
  assign lrep_wrap = lrep_inc >= {1'b0, lim_i.scale_y};
  assign col_wrap  = col_inc >= {1'b0, lim_i.width};
  assign line_wrap = line_inc >= {1'b0, lim_i.height};

  always_comb begin
    line_d = line_q;
    lrep_d = lrep_q;
    col_d  = col_q;
    prep_d = prep_q;
    if (step_i) begin
      prep_d = prep_wrap ? '0 : REP_W'(prep_inc);
      col_d  = cur_col;
      lrep_d = cur_lrep;
      line_d = cur_line;
      if (prep_wrap) begin
        col_d = col_wrap ? '0 : COL_W'(col_inc);
        if (col_wrap) begin
          lrep_d = lrep_wrap ? '0 : REP_W'(lrep_inc);
          if (lrep_wrap) line_d = line_wrap ? '0 : LINE_W'(line_inc);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= '0;
      lrep_q <= '0;
      col_q  <= '0;
      prep_q <= '0;
    end else begin
      line_q <= line_d;
      lrep_q <= lrep_d;
      col_q  <= col_d;
      prep_q <= prep_d;
    end
  end

  assign line_o = cur_line;
  assign col_o  = cur_col;
  assign last_o = (8'(cur_line) == lim_i.height - 8'd1) &&
                  (4'(cur_lrep) == lim_i.scale_y - 4'd1) &&
                  (8'(cur_col) == lim_i.width - 8'd1) &&
                  (4'(cur_prep) == lim_i.scale_x - 4'd1);

endmodule

`default_nettype wire

/* sv/color_keyed_framebuffer_upscaler_core.sv */
// ----------------------------------------------------------------------------
// color_keyed_framebuffer_upscaler_core: frame buffer with upscaled scan-out
// Stores RGB pixels with a transparent color key, answers reads and streams
// the frame with every pixel repeated scale_x times across and scale_y down.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Moves
//  s_axis    in         s_axis_tvalid/tready      one command item
//  m_axis    out        m_axis_tvalid/tready      one pixel item (read or scan)
//  cfg       in         cfg_valid/cfg_ready       one register write
//
// An item is taken in every cycle while the output is not stalled; a result
// passes through the input register and then the frame memory's read port.
// A stalled output holds its item, and s_axis_tready drops once the input
// register behind it is full too. After reset the memory is cleared one
// entry per cycle, all MAX_WIDTH*MAX_HEIGHT entries (16384 at the default
// size); no item is accepted meanwhile, while register writes are taken at once.
// ----------------------------------------------------------------------------
`default_nettype none

module color_keyed_framebuffer_upscaler_core
  import ckfu_pkg::*;
#(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int MAX_SCALE  = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // tdata, lowest bit up: row[6:0], col[13:7], red_in[22:14],
  // green_in[31:23], blue_in[40:32], zeros[47:41]
  input  wire logic [47:0] s_axis_tdata_i,
  // tuser: action[1:0]
  input  wire logic [1:0]  s_axis_tuser_i,

  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // tdata, lowest bit up: red_out[7:0], green_out[15:8], blue_out[23:16]
  output logic [23:0]      m_axis_tdata_o,
  // tuser: from_scan[0]
  output logic             m_axis_tuser_o,
  // tlast carries frame_end.
  output logic             m_axis_tlast_o,

  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);

  // Sizes that follow from the maxima. Register fields are eight and four
  // bits wide, which bounds the counters as well.
  localparam int DEPTH     = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WLIM      = (MAX_WIDTH < 255) ? MAX_WIDTH : 255;
  localparam int HLIM      = (MAX_HEIGHT < 255) ? MAX_HEIGHT : 255;
  localparam int SLIM      = (MAX_SCALE < 15) ? MAX_SCALE : 15;
  localparam int COL_W     = (WLIM > 1) ? $clog2(WLIM) : 1;
  localparam int LINE_W    = (HLIM > 1) ? $clog2(HLIM) : 1;
  localparam int REP_W     = (SLIM > 1) ? $clog2(SLIM) : 1;

  frame_lim_t lim;
  logic       clear_busy;

  // Input stage.
  logic       s1_valid_q;
  action_e    s1_action_q;
  logic [6:0] s1_row_q, s1_col_q;
  logic [8:0] s1_red_q, s1_green_q, s1_blue_q;

  // Result stage; the pixel itself sits in the memory's read register.
  logic       s2_valid_q;
  logic       s2_zero_q, s2_scan_q, s2_last_q;
  pixel_t     rd_data;

  logic              advance, s1_leave;
  logic              is_scan, is_read, is_write, is_key, in_frame;
  logic [LINE_W-1:0] scan_line;
  logic [COL_W-1:0]  scan_col;
  logic              scan_last;
  logic [7:0]        addr_row, addr_col;
  logic [15:0]       addr_full;
  logic [ADDR_W-1:0] addr;
  logic              wr_en, rd_en;
  pixel_t            wr_data;

  assign cfg_ready_o = 1'b1;

  ckfu_cfg_regs #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_SCALE (MAX_SCALE)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_index_i(cfg_index_i),
    .wr_data_i (cfg_data_i),
    .lim_o     (lim)
  );

  // The pipeline moves whenever the result register is free or being taken.
  assign advance         = !s2_valid_q || m_axis_tready_i;
  assign s1_leave        = s1_valid_q && advance;
  assign s_axis_tready_o = !clear_busy && (advance || !s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_axis_tvalid_i;
    end else if (s1_leave) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      s1_action_q <= action_e'(s_axis_tuser_i);
      s1_row_q    <= s_axis_tdata_i[6:0];
      s1_col_q    <= s_axis_tdata_i[13:7];
      s1_red_q    <= s_axis_tdata_i[22:14];
      s1_green_q  <= s_axis_tdata_i[31:23];
      s1_blue_q   <= s_axis_tdata_i[40:32];
    end
  end

  assign is_scan  = (s1_action_q == ACT_SCAN);
  assign is_read  = (s1_action_q == ACT_READ);
  assign is_write = (s1_action_q == ACT_WRITE);
  assign is_key   = (s1_red_q == COLOR_KEY) && (s1_green_q == COLOR_KEY) &&
                    (s1_blue_q == COLOR_KEY);
  assign in_frame = ({1'b0, s1_row_q} < lim.height) && ({1'b0, s1_col_q} < lim.width);

  ckfu_scan_ctrl #(
    .LINE_W(LINE_W),
    .COL_W (COL_W),
    .REP_W (REP_W)
  ) u_scan (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .lim_i (lim),
    .step_i(s1_leave && is_scan),
    .line_o(scan_line),
    .col_o (scan_col),
    .last_o(scan_last)
  );

  // Pixel (line, column) lives at line * width + column.
  assign addr_row  = is_scan ? 8'(scan_line) : {1'b0, s1_row_q};
  assign addr_col  = is_scan ? 8'(scan_col) : {1'b0, s1_col_q};
  assign addr_full = (addr_row * lim.width) + 16'(addr_col);
  assign addr      = ADDR_W'(addr_full);

  assign wr_en   = s1_leave && is_write && !is_key && in_frame;
  assign rd_en   = s1_leave && (is_read || is_scan);
  assign wr_data = '{red: s1_red_q[7:0], green: s1_green_q[7:0], blue: s1_blue_q[7:0]};

  ckfu_pixel_store #(
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (wr_en),
    .wr_addr_i   (addr),
    .wr_data_i   (wr_data),
    .rd_en_i     (rd_en),
    .rd_addr_i   (addr),
    .rd_data_o   (rd_data),
    .clear_busy_o(clear_busy)
  );

  // Writes and idle commands leave no result behind.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (advance) begin
      s2_valid_q <= s1_valid_q && (is_read || is_scan);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s2_zero_q <= is_read && !in_frame;
      s2_scan_q <= is_scan;
      s2_last_q <= is_scan && scan_last;
    end
  end

  assign m_axis_tvalid_o = s2_valid_q;
  assign m_axis_tdata_o  = s2_zero_q ? 24'd0
                                     : {rd_data.blue, rd_data.green, rd_data.red};
  assign m_axis_tuser_o  = s2_scan_q;
  assign m_axis_tlast_o  = s2_last_q;

endmodule

`default_nettype wire

/* bench/tb_color_keyed_framebuffer_upscaler_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_color_keyed_framebuffer_upscaler_core: self-checking bench of the core
// Commands go in as stream items and pixel items come back. A mirror of the
// frame store and the scan position predicts every read and scan pixel, and
// each arriving pixel is matched field by field against the oldest one due.
// A directed opening covers the corners of the frame, the color key, the
// range limits of the registers and the scan restart. Random phases follow,
// each under its own register setting, with bursty or steady input and a
// stalling output.
// ----------------------------------------------------------------------------

module tb_color_keyed_framebuffer_upscaler_core;
  import ckfu_pkg::*;

  localparam int FB_MAX_W       = 128;
  localparam int FB_MAX_H       = 128;
  localparam int FB_MAX_SCALE   = 8;
  localparam int RESET_CYCLES   = 12;
  // Writes leave no result behind, so the settle time lets the last of them
  // retire before a register write.
  localparam int PIPE_SETTLE    = 4;
  localparam int END_SETTLE     = 10;
  localparam int RAND_PHASES    = 9;
  localparam int PHASE_ITEMS    = 210;
  // The memory clear after reset and the slowest correct run both stay well
  // below this bound.
  localparam int TIMEOUT_CYCLES = 400_000;

  // One command as the core sees it.
  typedef struct packed {
    action_e    act;
    logic [6:0] row;
    logic [6:0] col;
    logic [8:0] red;
    logic [8:0] green;
    logic [8:0] blue;
  } command_t;

  // One pixel item as it leaves the core.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       from_scan;
    logic       frame_end;
  } pixel_out_t;

  // Mirror of the frame store, the registers and the scan position. It
  // produces the pixels that the core owes and checks the ones it delivers.
  class framebuffer_mirror;
    logic [7:0]  frame_width;
    logic [7:0]  frame_height;
    logic [3:0]  scale_x;
    logic [3:0]  scale_y;
    logic [23:0] store [FB_MAX_W * FB_MAX_H];
    int unsigned scan_row;
    int unsigned row_rep;
    int unsigned scan_col;
    int unsigned col_rep;
    pixel_out_t  pixels_due [$];
    int          errors;

    function new();
      frame_width  = RST_FRAME_WIDTH;
      frame_height = RST_FRAME_HEIGHT;
      scale_x      = RST_SCALE_X;
      scale_y      = RST_SCALE_Y;
      foreach (store[i]) store[i] = '0;
      scan_row = 0;
      row_rep  = 0;
      scan_col = 0;
      col_rep  = 0;
      errors   = 0;
    endfunction

    // Register values are used limited to 1 .. hi; zero counts as one.
    function int unsigned clamp(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned lim_width();
      return clamp(frame_width, FB_MAX_W);
    endfunction

    function int unsigned lim_height();
      return clamp(frame_height, FB_MAX_H);
    endfunction

    function int pending();
      return pixels_due.size();
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        REG_FRAME_WIDTH:  frame_width  = val;
        REG_FRAME_HEIGHT: frame_height = val;
        REG_SCALE_X:      scale_x      = val[3:0];
        REG_SCALE_Y:      scale_y      = val[3:0];
        default: ;
      endcase
    endfunction

    function void take_command(command_t c);
      int unsigned w;
      int unsigned h;
      int unsigned sx;
      int unsigned sy;
      int unsigned addr;
      bit          in_frame;
      bit          keyed;
      bit          last;
      logic [23:0] px;
      w  = lim_width();
      h  = lim_height();
      sx = clamp(scale_x, FB_MAX_SCALE);
      sy = clamp(scale_y, FB_MAX_SCALE);
      in_frame = (c.row < h) && (c.col < w);
      addr = c.row * w + c.col;
      keyed = (c.red == COLOR_KEY) && (c.green == COLOR_KEY) && (c.blue == COLOR_KEY);
      case (c.act)
        ACT_WRITE: begin
          // Only the low byte of each component is kept.
          if (!keyed && in_frame) store[addr] = {c.red[7:0], c.green[7:0], c.blue[7:0]};
        end
        ACT_READ: begin
          px = in_frame ? store[addr] : '0;
          pixels_due.push_back({px, 1'b0, 1'b0});
        end
        ACT_SCAN: begin
          // A register change can leave the position outside the frame;
          // the scan then starts over at the first pixel.
          if (scan_row >= h || row_rep >= sy || scan_col >= w || col_rep >= sx) begin
            scan_row = 0;
            row_rep  = 0;
            scan_col = 0;
            col_rep  = 0;
          end
          px   = store[scan_row * w + scan_col];
          last = (scan_row == h - 1) && (row_rep == sy - 1) &&
                 (scan_col == w - 1) && (col_rep == sx - 1);
          pixels_due.push_back({px, 1'b1, last});
          col_rep++;
          if (col_rep >= sx) begin
            col_rep = 0;
            scan_col++;
            if (scan_col >= w) begin
              scan_col = 0;
              row_rep++;
              if (row_rep >= sy) begin
                row_rep = 0;
                scan_row++;
                if (scan_row >= h) scan_row = 0;
              end
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void compare(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_pixel(pixel_out_t got);
      pixel_out_t want;
      if (pixels_due.size() == 0) begin
        $error("pixel item arrived with none due: red %0d green %0d blue %0d",
               got.red, got.green, got.blue);
        errors++;
        return;
      end
      want = pixels_due.pop_front();
      compare("red_out",   want.red,   got.red);
      compare("green_out", want.green, got.green);
      compare("blue_out",  want.blue,  got.blue);
      compare("from_scan", 8'(want.from_scan), 8'(got.from_scan));
      compare("frame_end", 8'(want.frame_end), 8'(got.frame_end));
    endfunction
  endclass

  // Receiver behavior: each stretch picks one of these for a random length.
  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_EVERY4,
    RX_BURSTS
  } rx_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;

  logic        s_axis_tvalid = 1'b0;
  wire         s_axis_tready_o;
  logic [47:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;

  wire         m_axis_tvalid_o;
  logic        m_axis_tready = 1'b0;
  wire  [23:0] m_axis_tdata_o;
  wire         m_axis_tuser_o;
  wire         m_axis_tlast_o;

  logic        cfg_valid = 1'b0;
  wire         cfg_ready_o;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  framebuffer_mirror mirror = new();

  // Register values for the next setting, indexed by register index.
  logic [7:0] reg_vals [4];
  bit   [3:0] reg_mask;

  // Sender burst state; a steady phase runs without gaps.
  int burst_left = 0;
  bit steady_sender = 1'b0;

  // Receiver pattern state.
  rx_mode_e rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       rx_tick = 0;
  int       rx_hold = 0;
  bit       rx_level = 1'b1;

  color_keyed_framebuffer_upscaler_core #(
    .MAX_WIDTH  (FB_MAX_W),
    .MAX_HEIGHT (FB_MAX_H),
    .MAX_SCALE  (FB_MAX_SCALE)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // The output side stalls in stretches: open, coin flips, one cycle in
  // four, or long alternating runs of stall and ready.
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(32, 200);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_OPEN:   m_axis_tready <= 1'b1;
      RX_COIN:   m_axis_tready <= ($urandom_range(0, 1) == 1);
      RX_EVERY4: m_axis_tready <= (rx_tick % 4 == 0);
      default: begin
        if (rx_hold == 0) begin
          rx_hold  = $urandom_range(1, 12);
          rx_level = !rx_level;
        end
        rx_hold--;
        m_axis_tready <= rx_level;
      end
    endcase
  end

  // Every pixel taken from the core is matched against the oldest one due.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready) begin
      mirror.check_pixel({m_axis_tdata_o[7:0], m_axis_tdata_o[15:8],
                          m_axis_tdata_o[23:16], m_axis_tuser_o, m_axis_tlast_o});
    end
  end

  function automatic command_t make_cmd(action_e a, int r, int c,
                                        logic [8:0] red, logic [8:0] green,
                                        logic [8:0] blue);
    command_t cmd;
    cmd.act   = a;
    cmd.row   = 7'(r);
    cmd.col   = 7'(c);
    cmd.red   = red;
    cmd.green = green;
    cmd.blue  = blue;
    return cmd;
  endfunction

  // A component is mostly a plain byte, now and then the key value -1.
  function automatic logic [8:0] random_component();
    if ($urandom_range(0, 9) == 0) return COLOR_KEY;
    return 9'($urandom_range(0, 255));
  endfunction

  // Random commands keep most coordinates inside the current frame so that
  // reads and scans return pixels that were actually drawn.
  function automatic command_t random_cmd();
    command_t    c;
    int unsigned w;
    int unsigned h;
    int unsigned p;
    w = mirror.lim_width();
    h = mirror.lim_height();
    p = $urandom_range(0, 99);
    if (p < 38) c.act = ACT_WRITE;
    else if (p < 60) c.act = ACT_READ;
    else if (p < 97) c.act = ACT_SCAN;
    else c.act = ACT_IDLE;
    c.row = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(0, h - 1))
                                          : 7'($urandom_range(0, 127));
    c.col = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(0, w - 1))
                                          : 7'($urandom_range(0, 127));
    c.red   = random_component();
    c.green = random_component();
    c.blue  = random_component();
    if ($urandom_range(0, 24) == 0) begin
      c.red   = COLOR_KEY;
      c.green = COLOR_KEY;
      c.blue  = COLOR_KEY;
    end
    return c;
  endfunction

  // Frame sizes are mostly tiny so that frame ends come often; zero and
  // values above the maximum exercise the range limit.
  function automatic logic [7:0] pick_size();
    int unsigned p;
    p = $urandom_range(0, 9);
    if (p == 0) return 8'd0;
    if (p == 1) return 8'($urandom_range(129, 255));
    if (p == 2) return 8'($urandom_range(9, 128));
    return 8'($urandom_range(1, 8));
  endfunction

  // Only the low nibble of a scale counts; the high nibble is random.
  function automatic logic [7:0] pick_scale();
    logic [3:0] low;
    low = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(1, 4)) : 4'($urandom_range(0, 15));
    return {4'($urandom_range(0, 15)), low};
  endfunction

  // Sends one command. The sender works in bursts of random length; a gap
  // of random length opens each burst unless the phase is steady.
  task automatic send_item(command_t c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady_sender ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, c.blue, c.green, c.red, c.col, c.row};
    s_axis_tuser  <= c.act;
    do @(posedge clk_i); while (!s_axis_tready_o);
    mirror.take_command(c);
  endtask

  // Stops sending and waits until every pixel due has arrived, then lets
  // the pipeline settle so that trailing writes have landed.
  task automatic drain(int settle);
    s_axis_tvalid <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Writes the registers selected by reg_mask with the values in reg_vals.
  task automatic program_regs();
    for (int i = 0; i < 4; i++) begin
      if (reg_mask[i]) begin
        cfg_valid <= 1'b1;
        cfg_index <= 2'(i);
        cfg_data  <= reg_vals[i];
        do @(posedge clk_i); while (!cfg_ready_o);
        mirror.set_reg(2'(i), reg_vals[i]);
      end
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset setting, 128 x 128 at scale one: the four corners, a write with
    // the key in only one component (stored as 255), a fully keyed write
    // that must leave the store alone, reads back, a few scan steps and an
    // idle action that must produce nothing. The first item waits out the
    // memory clear.
    send_item(make_cmd(ACT_WRITE, 0, 0, 9'd255, 9'd255, 9'd255));
    send_item(make_cmd(ACT_WRITE, 127, 127, 9'd1, 9'd2, 9'd3));
    send_item(make_cmd(ACT_WRITE, 127, 0, COLOR_KEY, 9'd0, 9'd255));
    send_item(make_cmd(ACT_WRITE, 0, 127, COLOR_KEY, COLOR_KEY, COLOR_KEY));
    send_item(make_cmd(ACT_READ, 0, 0, 9'd0, 9'd0, 9'd0));
    send_item(make_cmd(ACT_READ, 127, 127, 9'd0, 9'd0, 9'd0));
    send_item(make_cmd(ACT_READ, 127, 0, 9'd0, 9'd0, 9'd0));
    send_item(make_cmd(ACT_READ, 0, 127, 9'd0, 9'd0, 9'd0));
    send_item(make_cmd(ACT_SCAN, 0, 0, 9'd0, 9'd0, 9'd0));
    send_item(make_cmd(ACT_SCAN, 0, 0, 9'd0, 9'd0, 9'd0));
    send_item(make_cmd(ACT_SCAN, 0, 0, 9'd0, 9'd0, 9'd0));
    send_item(make_cmd(ACT_IDLE, 127, 127, 9'd255, 9'd255, 9'd255));

    // Out-of-range registers: width zero counts as one, height 200 is held
    // at 128, scale_x zero counts as one and scale_y 15 is held at eight.
    // The scan column left behind is now outside the frame, so the scan
    // restarts; accesses past column zero fall outside the frame.
    drain(PIPE_SETTLE);
    reg_vals[REG_FRAME_WIDTH]  = 8'd0;
    reg_vals[REG_FRAME_HEIGHT] = 8'd200;
    reg_vals[REG_SCALE_X]      = 8'hF0;
    reg_vals[REG_SCALE_Y]      = 8'h0F;
    reg_mask = 4'b1111;
    program_regs();
    send_item(make_cmd(ACT_SCAN, 0, 0, 9'd0, 9'd0, 9'd0));
    send_item(make_cmd(ACT_SCAN, 0, 0, 9'd0, 9'd0, 9'd0));
    send_item(make_cmd(ACT_WRITE, 5, 0, 9'd10, 9'd20, 9'd30));
    send_item(make_cmd(ACT_WRITE, 0, 5, 9'd40, 9'd50, 9'd60));
    send_item(make_cmd(ACT_READ, 0, 5, 9'd0, 9'd0, 9'd0));
    send_item(make_cmd(ACT_READ, 5, 0, 9'd0, 9'd0, 9'd0));

    // One line 255 wide (held at 128) with scale_x at its maximum: the line
    // repeat count left over is out of range, and row one is outside.
    drain(PIPE_SETTLE);
    reg_vals[REG_FRAME_WIDTH]  = 8'd255;
    reg_vals[REG_FRAME_HEIGHT] = 8'd1;
    reg_vals[REG_SCALE_X]      = 8'd8;
    reg_vals[REG_SCALE_Y]      = 8'd1;
    program_regs();
    send_item(make_cmd(ACT_SCAN, 0, 0, 9'd0, 9'd0, 9'd0));
    send_item(make_cmd(ACT_READ, 1, 0, 9'd0, 9'd0, 9'd0));

    // A single pixel frame: every scan pixel ends the frame.
    drain(PIPE_SETTLE);
    reg_vals[REG_FRAME_WIDTH]  = 8'd1;
    reg_vals[REG_FRAME_HEIGHT] = 8'd1;
    reg_vals[REG_SCALE_X]      = 8'd1;
    reg_vals[REG_SCALE_Y]      = 8'd1;
    program_regs();
    send_item(make_cmd(ACT_SCAN, 0, 0, 9'd0, 9'd0, 9'd0));
    send_item(make_cmd(ACT_SCAN, 0, 0, 9'd0, 9'd0, 9'd0));

    // Random phases. The first runs the largest frame at the largest
    // scales, the second the smallest; the rest draw a setting and rewrite
    // a random subset of the registers. Every third phase sends without
    // gaps. The core is drained before each new setting.
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      drain(PIPE_SETTLE);
      if (phase == 0) begin
        reg_vals[REG_FRAME_WIDTH]  = 8'd128;
        reg_vals[REG_FRAME_HEIGHT] = 8'd128;
        reg_vals[REG_SCALE_X]      = 8'd8;
        reg_vals[REG_SCALE_Y]      = 8'd8;
        reg_mask = 4'b1111;
      end else if (phase == 1) begin
        reg_vals[REG_FRAME_WIDTH]  = 8'd1;
        reg_vals[REG_FRAME_HEIGHT] = 8'd1;
        reg_vals[REG_SCALE_X]      = 8'd1;
        reg_vals[REG_SCALE_Y]      = 8'd1;
        reg_mask = 4'b1111;
      end else begin
        reg_vals[REG_FRAME_WIDTH]  = pick_size();
        reg_vals[REG_FRAME_HEIGHT] = pick_size();
        reg_vals[REG_SCALE_X]      = pick_scale();
        reg_vals[REG_SCALE_Y]      = pick_scale();
        reg_mask = 4'($urandom_range(1, 15));
      end
      program_regs();
      steady_sender = (phase % 3 == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_cmd());
    end

    drain(END_SETTLE);
    if (mirror.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard bound on the run in case the core stops answering.
  initial begin
    #(TIMEOUT_CYCLES * 2);
    $error("run did not finish within %0d cycles", TIMEOUT_CYCLES);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
